// ===== rtl/core/atid_pkg.sv =====
`timescale 1ns / 1ps

package atid_pkg;

   localparam int CAPACITY = 64;

   localparam int OP_W     = 3;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int RSP_CNT_W = 7;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [OP_W-1:0] OP_INS_ORD = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_UNO = 3'd1;
   localparam logic [OP_W-1:0] OP_DEL_ORD = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_UNO = 3'd3;
   localparam logic [OP_W-1:0] OP_READ    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                     go;
      logic [OP_W-1:0]          op;
      logic [CMP_W-1:0]         pos;
      logic [CMP_W-1:0]         count;
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] rd_pos;
      logic signed [DATA_W-1:0] rd_last;
   } cell_cmd_type;

endpackage

// ===== rtl/core/atid_cell.sv =====
`timescale 1ns / 1ps

module atid_cell
   import atid_pkg::*;
(
   input  logic                     clock,
   input  logic [CMP_W-1:0]         idx,
   input  cell_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data_q
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic [CMP_W-1:0]         last_idx;

   assign last_idx = cmd.count - CMP_W'(1);

   always_comb begin
      data_in = data_ff;
      if (cmd.go) begin
         unique case (cmd.op)
            OP_INS_ORD: begin
               if (idx == cmd.pos) begin
                  data_in = cmd.val;
               end else if (idx > cmd.pos && idx <= cmd.count) begin
                  data_in = left_data;
               end
            end
            OP_INS_UNO: begin
               if (idx == cmd.pos) begin
                  data_in = cmd.val;
               end else if (idx == cmd.count) begin
                  data_in = cmd.rd_pos;
               end
            end
            OP_DEL_ORD: begin
               if (idx >= cmd.pos && idx < last_idx) begin
                  data_in = right_data;
               end
            end
            OP_DEL_UNO: begin
               if (idx == cmd.pos) begin
                  data_in = cmd.rd_last;
               end
            end
            default: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

// ===== rtl/core/array_table_insert_delete.sv =====
`timescale 1ns / 1ps
// channel   ports                                              direction
// request   req_valid req_ready req_op req_position req_value  in
// response  rsp_valid rsp_ready rsp_status rsp_entry_count
//           rsp_read_value                                     out
//
// Each request is first captured, then executed: in the execute state every cell
// of the entry chain updates in parallel and the response register loads.
// Reset clears the count and the handshake state; entries are not cleared.
// A response held by rsp_ready stalls the execute cycle of the next request;
// a new request is taken while the previous response still waits.

module array_table_insert_delete
   import atid_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_op,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [RSP_CNT_W-1:0]       rsp_entry_count,
   output logic signed [DATA_W-1:0]   rsp_read_value
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic                     state_ff, state_in;
   logic [OP_W-1:0]          op_ff;
   logic [CMP_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      status_ff;
   logic [CNT_W-1:0]         rcount_ff;
   logic signed [DATA_W-1:0] rdata_ff;

   logic                     accept;
   logic                     fire;
   logic [CMP_W-1:0]         count_ext;
   logic [STATUS_W-1:0]      status;
   logic                     ok_mut;
   logic signed [DATA_W-1:0] rd_pos;
   logic signed [DATA_W-1:0] rd_last;
   cell_cmd_type             cmd;
   logic signed [DATA_W-1:0] cell_q [CAPACITY];

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign fire      = (state_ff == S_EXEC) & (~rsp_valid_ff | rsp_ready);
   assign count_ext = CMP_W'(count_ff);

   always_comb begin
      status = ST_OK;
      unique case (op_ff)
         OP_INS_ORD, OP_INS_UNO: begin
            if (count_ff >= CNT_W'(CAPACITY)) begin
               status = ST_FULL;
            end else if (pos_ff > count_ext) begin
               status = ST_RANGE;
            end
         end
         OP_DEL_ORD, OP_DEL_UNO, OP_READ: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (pos_ff >= count_ext) begin
               status = ST_RANGE;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign ok_mut = fire & (status == ST_OK) & (op_ff <= OP_DEL_UNO);

   // one-hot select over the cells
   always_comb begin
      rd_pos  = '0;
      rd_last = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CMP_W'(i) == pos_ff) begin
            rd_pos = rd_pos | cell_q[i];
         end
         if (CMP_W'(i) == count_ext - CMP_W'(1)) begin
            rd_last = rd_last | cell_q[i];
         end
      end
   end

   always_comb begin
      cmd.go      = ok_mut;
      cmd.op      = op_ff;
      cmd.pos     = pos_ff;
      cmd.count   = count_ext;
      cmd.val     = val_ff;
      cmd.rd_pos  = rd_pos;
      cmd.rd_last = rd_last;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_d;
      logic signed [DATA_W-1:0] right_d;
      if (g == 0) begin : g_first
         assign left_d = '0;
      end else begin : g_left
         assign left_d = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_right
         assign right_d = cell_q[g+1];
      end
      atid_cell u_cell (
         .clock      (clock),
         .idx        (CMP_W'(g)),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .data_q     (cell_q[g])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ok_mut) begin
         if (op_ff == OP_INS_ORD || op_ff == OP_INS_UNO) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = S_EXEC;
      end else if (fire) begin
         state_in = S_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         pos_ff <= CMP_W'(req_position);
         val_ff <= req_value;
      end
      if (fire) begin
         status_ff <= status;
         rcount_ff <= count_in;
         rdata_ff  <= (op_ff == OP_READ && status == ST_OK) ? rd_pos : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = RSP_CNT_W'(rcount_ff);
   assign rsp_read_value  = rdata_ff;

endmodule

// ===== rtl/core/atid_checker.sv =====
`timescale 1ns / 1ps

module atid_checker
   import atid_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic [RSP_CNT_W-1:0]     rsp_entry_count,
   input logic signed [DATA_W-1:0] rsp_read_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == RSP_CNT_W'(CAPACITY))
      else $error("full status with count below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == '0)
      else $error("empty status with nonzero count");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
      else $error("rejected request returned data");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("handshake not idle after reset");

endmodule

bind array_table_insert_delete atid_checker u_atid_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_read_value  (rsp_read_value)
);
